// ===== rtl/zncc_window_correlator_assert.svh =====
// Assertion helpers for the window correlator. Each helper samples on clk_i and is
// disabled while rst_ni is low.
`ifndef ZNCC_WINDOW_CORRELATOR_ASSERT_SVH
`define ZNCC_WINDOW_CORRELATOR_ASSERT_SVH

`define ZNCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zncc: same-cycle check failed");

`define ZNCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zncc: next-cycle check failed");

`endif

// ===== rtl/zncc_pkg.sv =====
package zncc_pkg;

  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned SCORE_FRAC = 15;
  localparam int unsigned ROOT_BITS  = 16;
  localparam int unsigned SQ_SHIFT   = 2 * SCORE_FRAC;

  typedef logic [PIXEL_W-1:0]        pixel_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  localparam score_t SCORE_MAX = 16'sh7fff;

endpackage

// ===== rtl/zncc_pair_if.sv =====
interface zncc_pair_if;
  import zncc_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel_a;
  pixel_t pixel_b;
  logic   last;

  modport source (output valid, output pixel_a, output pixel_b, output last, input ready);
  modport sink (input valid, input pixel_a, input pixel_b, input last, output ready);

endinterface

// ===== rtl/zncc_score_if.sv =====
interface zncc_score_if;
  import zncc_pkg::*;

  logic   valid;
  logic   ready;
  score_t correlation;
  logic   degenerate;

  modport source (output valid, output correlation, output degenerate, input ready);
  modport sink (input valid, input correlation, input degenerate, output ready);

endinterface

// ===== rtl/zncc_ser_mul.sv =====
module zncc_ser_mul #(
  parameter int unsigned AW = 82,
  parameter int unsigned BW = 41
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic             done_o,
  output logic [AW+BW-1:0] prod_o
);

  localparam int unsigned CNW = $clog2(BW + 1);

  logic [AW-1:0]    a_q;
  logic [AW+BW-1:0] prod_q;
  logic [CNW-1:0]   cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [AW:0]      sum;

  // The multiplier bits leave the low end of the product register one per cycle.
  assign sum = {1'b0, prod_q[AW+BW-1:BW]} + (prod_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(BW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNW'(1);
        if (cnt_q == CNW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      prod_q <= {{AW{1'b0}}, b_i};
    end else if (busy_q) begin
      prod_q <= {sum, prod_q[BW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/zncc_window_correlator.sv =====
// Zero-mean normalised cross-correlation of two equal-size image windows.
// Pixel pairs arrive on pair_i, one pair per transfer, with last marking the final
// pair of a window. The block accumulates the count, the sums, the sums of squares
// and the cross sum at one pair per cycle while ready is high. Pairs beyond MAX_PIXELS are ignored.
// After the transfer marked last, ready stays low while the score is formed by one
// shift-and-add multiplier that takes one multiplier bit per cycle. Its multiplier width
// BW is the larger of 32 and the variance width (41 bits at the default sizes). A normal
// window needs 24 products (eight for the moments and sixteen for the bit-by-bit root
// search). A window with zero variance needs only six products.
// The score leaves on score_o as signed Q1.15 with a degenerate flag. It waits in an
// output register, so a new window may stream in while the receiver stalls.
// A second score waits inside the block until the register is free.
// Reset clears the accumulators and drops any pending result.
`include "zncc_window_correlator_assert.svh"

module zncc_window_correlator #(
  parameter int unsigned MAX_PIXELS = 4096,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  zncc_pair_if.sink   pair_i,
  zncc_score_if.source score_o
);
  import zncc_pkg::*;

  localparam int unsigned     PW   = (PIXEL_BITS < PIXEL_W) ? PIXEL_BITS : PIXEL_W;
  localparam longint unsigned PMAX = (64'd1 << PIXEL_BITS) - 64'd1;
  localparam int unsigned     CW   = $clog2(MAX_PIXELS + 1);
  localparam int unsigned     SW   = $clog2(longint'(MAX_PIXELS) * PMAX + 1);
  localparam int unsigned     QW   = $clog2(longint'(MAX_PIXELS) * PMAX * PMAX + 1);
  localparam int unsigned     VW   = CW + QW;
  localparam int unsigned     AW   = 2 * VW;
  localparam int unsigned     BW   = (VW > 2 * ROOT_BITS) ? VW : 2 * ROOT_BITS;
  localparam int unsigned     KW   = $clog2(ROOT_BITS);

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_LAUNCH,
    ST_WAIT,
    ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NSAA,
    OP_SA2,
    OP_NSBB,
    OP_SB2,
    OP_NSAB,
    OP_SASB,
    OP_VV,
    OP_CC,
    OP_TRIAL
  } op_e;

  state_e state_q;
  op_e    op_q;

  logic [CW-1:0] cnt_q;
  logic [SW-1:0] sa_q, sb_q;
  logic [QW-1:0] saa_q, sbb_q, sab_q;

  logic [VW-1:0]        hold_q, va_q, vb_q, c_q;
  logic [AW-1:0]        p_q, r_q;
  logic [ROOT_BITS-1:0] q_q;
  logic [KW-1:0]        k_q;
  logic                 neg_q, deg_q;
  logic                 out_valid_q;
  score_t               corr_q;
  logic                 degen_q;

  logic [PW-1:0]          pa, pb;
  logic [2*PW-1:0]        pa_sq, pb_sq, pab;
  logic                   accept, room;
  logic                   mul_start, mul_done;
  logic [AW-1:0]          mul_a;
  logic [BW-1:0]          mul_b;
  logic [AW+BW-1:0]       mul_prod, rhs;
  logic [VW-1:0]          prod_v;
  logic                   c_neg, fits, out_free;
  logic [ROOT_BITS-1:0]   trial;
  logic [2*ROOT_BITS-1:0] trial_sq;
  score_t                 score_d;

  assign pa     = pair_i.pixel_a[PW-1:0];
  assign pb     = pair_i.pixel_b[PW-1:0];
  assign pa_sq  = {{PW{1'b0}}, pa} * {{PW{1'b0}}, pa};
  assign pb_sq  = {{PW{1'b0}}, pb} * {{PW{1'b0}}, pb};
  assign pab    = {{PW{1'b0}}, pa} * {{PW{1'b0}}, pb};
  assign accept = pair_i.valid && pair_i.ready;
  assign room   = cnt_q < CW'(MAX_PIXELS);

  assign pair_i.ready = (state_q == ST_ACCUM);

  assign prod_v   = mul_prod[VW-1:0];
  assign c_neg    = hold_q < prod_v;
  assign trial    = q_q | (ROOT_BITS'(1) << k_q);
  assign trial_sq = {{ROOT_BITS{1'b0}}, trial} * {{ROOT_BITS{1'b0}}, trial};
  assign rhs      = (AW+BW)'({r_q, {SQ_SHIFT{1'b0}}});
  assign fits     = mul_prod <= rhs;
  assign out_free = !out_valid_q || score_o.ready;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_q)
      OP_NSAA: begin
        mul_a = AW'(saa_q);
        mul_b = BW'(cnt_q);
      end
      OP_SA2: begin
        mul_a = AW'(sa_q);
        mul_b = BW'(sa_q);
      end
      OP_NSBB: begin
        mul_a = AW'(sbb_q);
        mul_b = BW'(cnt_q);
      end
      OP_SB2: begin
        mul_a = AW'(sb_q);
        mul_b = BW'(sb_q);
      end
      OP_NSAB: begin
        mul_a = AW'(sab_q);
        mul_b = BW'(cnt_q);
      end
      OP_SASB: begin
        mul_a = AW'(sa_q);
        mul_b = BW'(sb_q);
      end
      OP_VV: begin
        mul_a = AW'(va_q);
        mul_b = BW'(vb_q);
      end
      OP_CC: begin
        mul_a = AW'(c_q);
        mul_b = BW'(c_q);
      end
      OP_TRIAL: begin
        mul_a = p_q;
        mul_b = BW'(trial_sq);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_start = (state_q == ST_LAUNCH);

  zncc_ser_mul #(
    .AW(AW),
    .BW(BW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  always_comb begin
    if (deg_q) begin
      score_d = '0;
    end else if (neg_q) begin
      score_d = score_t'(ROOT_BITS'(0) - q_q);
    end else if (q_q[ROOT_BITS-1]) begin
      score_d = SCORE_MAX;
    end else begin
      score_d = score_t'(q_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      op_q        <= OP_NSAA;
      cnt_q       <= '0;
      sa_q        <= '0;
      sb_q        <= '0;
      saa_q       <= '0;
      sbb_q       <= '0;
      sab_q       <= '0;
      q_q         <= '0;
      k_q         <= '0;
      neg_q       <= 1'b0;
      deg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      corr_q      <= '0;
      degen_q     <= 1'b0;
    end else begin
      if (score_o.ready && state_q != ST_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_ACCUM: begin
          if (accept) begin
            if (room) begin
              cnt_q <= cnt_q + CW'(1);
              sa_q  <= sa_q + SW'(pa);
              sb_q  <= sb_q + SW'(pb);
              saa_q <= saa_q + QW'(pa_sq);
              sbb_q <= sbb_q + QW'(pb_sq);
              sab_q <= sab_q + QW'(pab);
            end
            if (pair_i.last) begin
              op_q    <= OP_NSAA;
              state_q <= ST_LAUNCH;
            end
          end
        end
        ST_LAUNCH: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (mul_done) begin
            state_q <= ST_LAUNCH;
            case (op_q)
              OP_NSAA: op_q <= OP_SA2;
              OP_SA2:  op_q <= OP_NSBB;
              OP_NSBB: op_q <= OP_SB2;
              OP_SB2:  op_q <= OP_NSAB;
              OP_NSAB: op_q <= OP_SASB;
              OP_SASB: begin
                neg_q <= c_neg;
                if (va_q == '0 || vb_q == '0) begin
                  deg_q   <= 1'b1;
                  state_q <= ST_EMIT;
                end else begin
                  deg_q <= 1'b0;
                  op_q  <= OP_VV;
                end
              end
              OP_VV: op_q <= OP_CC;
              OP_CC: begin
                q_q  <= '0;
                k_q  <= KW'(ROOT_BITS - 1);
                op_q <= OP_TRIAL;
              end
              OP_TRIAL: begin
                if (fits) begin
                  q_q <= trial;
                end
                if (k_q == '0) begin
                  state_q <= ST_EMIT;
                end else begin
                  k_q <= k_q - KW'(1);
                end
              end
              default: state_q <= ST_EMIT;
            endcase
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            corr_q      <= score_d;
            degen_q     <= deg_q;
            cnt_q       <= '0;
            sa_q        <= '0;
            sb_q        <= '0;
            saa_q       <= '0;
            sbb_q       <= '0;
            sab_q       <= '0;
            state_q     <= ST_ACCUM;
          end
        end
        default: state_q <= ST_ACCUM;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WAIT && mul_done) begin
      case (op_q)
        OP_NSAA, OP_NSBB, OP_NSAB: hold_q <= prod_v;
        OP_SA2:  va_q <= hold_q - prod_v;
        OP_SB2:  vb_q <= hold_q - prod_v;
        OP_SASB: c_q  <= c_neg ? (prod_v - hold_q) : (hold_q - prod_v);
        OP_VV:   p_q  <= mul_prod[AW-1:0];
        OP_CC:   r_q  <= mul_prod[AW-1:0];
        default: ;
      endcase
    end
  end

  assign score_o.valid       = out_valid_q;
  assign score_o.correlation = corr_q;
  assign score_o.degenerate  = degen_q;

  `ZNCC_ASSERT_NEXT(a_last_stalls, accept && pair_i.last, !pair_i.ready)
  `ZNCC_ASSERT_IMP(a_degen_zero, score_o.valid && score_o.degenerate, score_o.correlation == '0)
  `ZNCC_ASSERT_IMP(a_mul_sync, mul_done, state_q == ST_WAIT)

endmodule

// ===== dv/zncc_score_checker.sv =====
module zncc_score_checker #(
  parameter int unsigned MAX_PIXELS = 4096,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  zncc_pair_if        pair_i,
  zncc_score_if       score_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import zncc_pkg::*;

  typedef struct packed {
    score_t correlation;
    logic   degenerate;
  } score_rec_t;

  logic [12:0] pair_count;
  logic [19:0] sum_a;
  logic [19:0] sum_b;
  logic [27:0] sum_sq_a;
  logic [27:0] sum_sq_b;
  logic [27:0] sum_cross;
  score_rec_t  score_q[$];
  int unsigned mismatches;

  // The magnitude is the largest q with q^2 * Va * Vb <= 2^30 * C^2, found by bisection.
  function automatic score_rec_t window_score(input logic [12:0] n, input logic [19:0] sa,
                                              input logic [19:0] sb, input logic [27:0] saa,
                                              input logic [27:0] sbb, input logic [27:0] sab);
    logic [63:0]  var_a;
    logic [63:0]  var_b;
    logic [63:0]  prod_n;
    logic [63:0]  prod_s;
    logic [63:0]  cov_mag;
    logic [127:0] var_prod;
    logic [127:0] cov_sq;
    logic [127:0] root_sq;
    logic         neg;
    int unsigned  lo;
    int unsigned  hi;
    int unsigned  mid;
    score_rec_t   r;
    var_a  = 64'(n) * 64'(saa) - 64'(sa) * 64'(sa);
    var_b  = 64'(n) * 64'(sbb) - 64'(sb) * 64'(sb);
    prod_n = 64'(n) * 64'(sab);
    prod_s = 64'(sa) * 64'(sb);
    neg    = prod_n < prod_s;
    cov_mag = neg ? prod_s - prod_n : prod_n - prod_s;
    r.correlation = '0;
    r.degenerate  = 1'b0;
    if (var_a == 0 || var_b == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    var_prod = 128'(var_a) * 128'(var_b);
    cov_sq   = (128'(cov_mag) * 128'(cov_mag)) << SQ_SHIFT;
    lo = 0;
    hi = 1 << SCORE_FRAC;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      root_sq = 128'(64'(mid) * 64'(mid)) * var_prod;
      if (root_sq <= cov_sq) lo = mid;
      else hi = mid - 1;
    end
    if (neg) begin
      r.correlation = score_t'(-int'(lo));
    end else begin
      r.correlation = (lo > int'(SCORE_MAX)) ? SCORE_MAX : score_t'(lo);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    score_rec_t got;
    score_rec_t want;
    pixel_t     a;
    pixel_t     b;
    if (!rst_ni) begin
      pair_count = '0;
      sum_a      = '0;
      sum_b      = '0;
      sum_sq_a   = '0;
      sum_sq_b   = '0;
      sum_cross  = '0;
      score_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (score_i.valid && score_i.ready) begin
        got.correlation = score_i.correlation;
        got.degenerate  = score_i.degenerate;
        if (score_q.size() == 0) begin
          $display("%0t: score transfer with none expected: correlation %0d degenerate %0b",
                   $time, got.correlation, got.degenerate);
          mismatches++;
        end else begin
          want = score_q.pop_front();
          if (got.correlation !== want.correlation) begin
            $display("%0t: correlation expected %0d, got %0d", $time, want.correlation,
                     got.correlation);
            mismatches++;
          end
          if (got.degenerate !== want.degenerate) begin
            $display("%0t: degenerate expected %0b, got %0b", $time, want.degenerate,
                     got.degenerate);
            mismatches++;
          end
        end
      end
      if (pair_i.valid && pair_i.ready) begin
        a = pair_i.pixel_a & pixel_t'((1 << PIXEL_BITS) - 1);
        b = pair_i.pixel_b & pixel_t'((1 << PIXEL_BITS) - 1);
        if (pair_count < MAX_PIXELS) begin
          pair_count = pair_count + 1'b1;
          sum_a      = sum_a + a;
          sum_b      = sum_b + b;
          sum_sq_a   = sum_sq_a + a * a;
          sum_sq_b   = sum_sq_b + b * b;
          sum_cross  = sum_cross + a * b;
        end
        if (pair_i.last) begin
          score_q.push_back(window_score(pair_count, sum_a, sum_b, sum_sq_a, sum_sq_b,
                                         sum_cross));
          pair_count = '0;
          sum_a      = '0;
          sum_b      = '0;
          sum_sq_a   = '0;
          sum_sq_b   = '0;
          sum_cross  = '0;
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= score_q.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  import zncc_pkg::*;

  localparam int unsigned MAX_PIXELS   = 4096;
  localparam int unsigned PIXEL_BITS   = 8;
  localparam int unsigned RANDOM_ITEMS = 400;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned STALL_LIMIT  = 20000;

  typedef enum int unsigned {
    WIN_RANDOM,
    WIN_MATCHED,
    WIN_INVERTED,
    WIN_FLAT,
    WIN_EXTREME
  } window_kind_e;

  logic        clk_i;
  logic        rst_ni;
  logic        steady;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles;
  int unsigned random_sent;

  zncc_pair_if  pair_if ();
  zncc_score_if score_if ();

  zncc_window_correlator #(
    .MAX_PIXELS(MAX_PIXELS),
    .PIXEL_BITS(PIXEL_BITS)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pair_i (pair_if),
    .score_o(score_if)
  );

  zncc_score_checker #(
    .MAX_PIXELS(MAX_PIXELS),
    .PIXEL_BITS(PIXEL_BITS)
  ) score_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pair_i      (pair_if),
    .score_i     (score_if),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(negedge clk_i) begin
    score_if.ready <= steady || ($urandom_range(99) >= 12);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((pair_if.valid && pair_if.ready) || (score_if.valid && score_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called just after a falling edge; returns just after the falling edge that follows
  // the transfer.
  task automatic send_pair(input pixel_t a, input pixel_t b, input logic last);
    while (!steady && $urandom_range(99) < 12) begin
      pair_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pair_if.valid   <= 1'b1;
    pair_if.pixel_a <= a;
    pair_if.pixel_b <= b;
    pair_if.last    <= last;
    do @(posedge clk_i); while (!pair_if.ready);
    @(negedge clk_i);
  endtask

  task automatic send_window(input window_kind_e kind, input int unsigned len);
    pixel_t a;
    pixel_t b;
    pixel_t flat;
    int     shifted;
    flat = 8'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      a = 8'($urandom);
      b = 8'($urandom);
      case (kind)
        WIN_MATCHED: begin
          shifted = int'(a) + $urandom_range(16) - 8;
          b = (shifted < 0) ? 8'd0 : (shifted > 255) ? 8'd255 : 8'(shifted);
        end
        WIN_INVERTED: begin
          b = ~a ^ 8'($urandom_range(3));
        end
        WIN_FLAT: begin
          if ($urandom_range(1)) a = flat;
          else b = flat;
        end
        WIN_EXTREME: begin
          a = $urandom_range(1) ? 8'd255 : 8'd0;
          b = $urandom_range(1) ? 8'd255 : 8'd0;
        end
        default: ;
      endcase
      send_pair(a, b, i == len - 1);
    end
  endtask

  initial begin
    window_kind_e kind;
    int unsigned  len;
    int unsigned  pick;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    steady          = 1'b0;
    quiet_cycles    = 0;
    random_sent     = 0;
    pair_if.valid   = 1'b0;
    pair_if.pixel_a = '0;
    pair_if.pixel_b = '0;
    pair_if.last    = 1'b0;
    score_if.ready  = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A single pair and windows with one flat side have zero variance.
    send_pair(8'd255, 8'd0, 1'b1);
    send_pair(8'd7, 8'd0, 1'b0);
    send_pair(8'd7, 8'd255, 1'b0);
    send_pair(8'd7, 8'd9, 1'b1);
    send_pair(8'd0, 8'd128, 1'b0);
    send_pair(8'd255, 8'd128, 1'b1);
    // Perfect correlation saturates; perfect anti-correlation reaches the negative limit.
    send_pair(8'd0, 8'd0, 1'b0);
    send_pair(8'd255, 8'd255, 1'b1);
    send_pair(8'd0, 8'd255, 1'b0);
    send_pair(8'd255, 8'd0, 1'b1);
    send_pair(8'd10, 8'd200, 1'b0);
    send_pair(8'd200, 8'd30, 1'b0);
    send_pair(8'd90, 8'd90, 1'b0);
    send_pair(8'd255, 8'd1, 1'b0);
    send_pair(8'd1, 8'd254, 1'b0);
    send_pair(8'd128, 8'd127, 1'b1);

    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 5) len = 1;
      else if (pick < 85) len = $urandom_range(16, 2);
      else len = $urandom_range(60, 17);
      kind = window_kind_e'($urandom_range(WIN_EXTREME));
      steady = (random_sent >= 150) && (random_sent < 250);
      send_window(kind, len);
      random_sent += len;
    end
    steady = 1'b0;
    pair_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
